// ===== rtl/chunk_cache_lru_lookup_core_macros.svh =====
// Assertion macros used by the chunk cache lookup RTL.
`ifndef CHUNK_CACHE_LRU_LOOKUP_CORE_MACROS_SVH
`define CHUNK_CACHE_LRU_LOOKUP_CORE_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define CCL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent, outside reset.
`define CCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/ccl_pkg.sv =====
`default_nettype none
package ccl_pkg;
   localparam int CacheSlotsDef   = 1024;
   localparam int ChunkBytesDef   = 2048;
   localparam int MaxRomChunksDef = 32768;
   localparam int StampBitsDef    = 32;
   localparam int SlotW           = 10;
   localparam int EvChunkW        = 15;
   localparam int CountW          = 16;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CLEAR,
      BK_MAP_RD,
      BK_SCAN,
      BK_SLOT_RD,
      BK_FIX,
      BK_DONE
   } bk_state_type;

   typedef struct packed {
      logic        in_range;
      logic [31:0] offset;
   } fe_item_type;

   typedef struct packed {
      logic        in_range;
      logic [SlotW-1:0] slot;
      logic [31:0] chunk_start;
      logic        load_needed;
      logic        evicted_valid;
      logic [EvChunkW-1:0] evicted_chunk;
   } rsp_item_type;
endpackage
`default_nettype wire

// ===== rtl/chunk_cache_lru_lookup_core.sv =====
// Items are taken one at a time, only while idle and the response is free;
// out-of-range items are answered from idle, hits after the map read, and
// misses after a victim scan (one stamp per cycle from the stamp RAM), so
// misses serialize on the scan. Reset (and every csr write) runs a clearing
// pass over max(MaxRomChunks, CacheSlots) entries; meanwhile queued items wait.
`default_nettype none
module chunk_cache_lru_lookup_core
   import ccl_pkg::*;
#(
   parameter int CacheSlots   = CacheSlotsDef,
   parameter int ChunkBytes   = ChunkBytesDef,
   parameter int MaxRomChunks = MaxRomChunksDef,
   parameter int StampBits    = StampBitsDef
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   output logic      full,
   input  wire logic [31:0] req_rom_offset,
   output logic      empty,
   input  wire logic pop,
   output logic      rsp_in_range,
   output logic [SlotW-1:0] rsp_slot,
   output logic [31:0] rsp_chunk_start,
   output logic      rsp_load_needed,
   output logic      rsp_evicted_valid,
   output logic [EvChunkW-1:0] rsp_evicted_chunk,
   input  wire logic csr_we,
   input  wire logic [CountW-1:0] csr_wdata
);
   logic [CountW-1:0] count_ff;
   logic         q_valid, q_pop, rsp_valid;
   fe_item_type  q_item;
   rsp_item_type rsp_item;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (csr_we) count_ff <= csr_wdata;
   end

   ccl_front #(.ChunkBytes(ChunkBytes), .MaxRomChunks(MaxRomChunks)) u_front (
      .clock, .reset, .push, .full, .req_rom_offset,
      .chunk_count(count_ff), .q_valid, .q_pop, .q_item);

   ccl_back #(.CacheSlots(CacheSlots), .ChunkBytes(ChunkBytes),
      .MaxRomChunks(MaxRomChunks), .StampBits(StampBits)) u_back (
      .clock, .reset, .clear_req(csr_we), .q_valid, .q_pop, .q_item,
      .rsp_valid, .rsp_take(pop), .rsp_item);

   assign empty             = !rsp_valid;
   assign rsp_in_range      = rsp_item.in_range;
   assign rsp_slot          = rsp_item.slot;
   assign rsp_chunk_start   = rsp_item.chunk_start;
   assign rsp_load_needed   = rsp_item.load_needed;
   assign rsp_evicted_valid = rsp_item.evicted_valid;
   assign rsp_evicted_chunk = rsp_item.evicted_chunk;
endmodule
`default_nettype wire

// ===== rtl/ccl_ram.sv =====
`default_nettype none
module ccl_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/ccl_front.sv =====
`default_nettype none
module ccl_front
   import ccl_pkg::*;
#(
   parameter int ChunkBytes   = ChunkBytesDef,
   parameter int MaxRomChunks = MaxRomChunksDef
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [31:0]       req_rom_offset,
   input  wire logic [CountW-1:0] chunk_count,
   output logic                   q_valid,
   input  wire logic              q_pop,
   output fe_item_type            q_item
);
   localparam int ChunkSh = $clog2(ChunkBytes);

   fe_item_type q_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff;
   logic [31:0] chunk;
   logic [32:0] limit;
   logic        acc, deq;

   assign chunk = req_rom_offset >> ChunkSh;
   always_comb begin
      limit = {17'd0, chunk_count};
      if (limit > 33'(MaxRomChunks)) begin
         limit = 33'(MaxRomChunks);
      end
   end

   assign full    = (cnt_ff == 2'd2);
   assign acc     = push && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign deq     = q_valid && q_pop;
   assign q_item  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (acc) begin
         q_ff[wr_ptr_ff].in_range <= ({1'b0, chunk} < limit);
         q_ff[wr_ptr_ff].offset   <= req_rom_offset;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (acc) wr_ptr_ff <= !wr_ptr_ff;
         if (deq) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(acc) - 2'(deq);
      end
   end
endmodule
`default_nettype wire

// ===== rtl/ccl_back.sv =====
`default_nettype none
`include "chunk_cache_lru_lookup_core_macros.svh"
module ccl_back
   import ccl_pkg::*;
#(
   parameter int CacheSlots   = CacheSlotsDef,
   parameter int ChunkBytes   = ChunkBytesDef,
   parameter int MaxRomChunks = MaxRomChunksDef,
   parameter int StampBits    = StampBitsDef
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic clear_req,
   input  wire logic q_valid,
   output logic      q_pop,
   input  wire fe_item_type q_item,
   output logic      rsp_valid,
   input  wire logic rsp_take,
   output rsp_item_type rsp_item
);
   localparam int ChunkSh = $clog2(ChunkBytes);
   localparam int SIdxW   = $clog2(CacheSlots);
   localparam int MapW    = (MaxRomChunks > 1) ? $clog2(MaxRomChunks) : 1;
   localparam int ChunkW  = 32 - ChunkSh;
   localparam int ClrN    = (MaxRomChunks > CacheSlots) ? MaxRomChunks : CacheSlots;
   localparam int ClrW    = $clog2(ClrN + 1);

   bk_state_type state_ff, state_in;
   logic [ClrW-1:0]  clr_ff, clr_in;
   logic             clr_pend_ff;
   logic [StampBits-1:0] ctr_ff, ctr_in;
   fe_item_type      cur_ff, cur_in;
   logic [SIdxW:0]   scan_ff, scan_in;
   logic [SIdxW-1:0] best_ff, best_in;
   logic [StampBits-1:0] best_st_ff, best_st_in;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_ff, rsp_in;
   logic             rsp_load;
   logic [ChunkW-1:0] chunk;

   // map entry: valid + slot; slot entry: valid + chunk
   logic             map_we;
   logic [MapW-1:0]  map_wa, map_ra;
   logic [SIdxW:0]   map_wd, map_rd;
   logic             sc_we;
   logic [SIdxW-1:0] sc_wa, sc_ra;
   logic [ChunkW:0]  sc_wd, sc_rd;
   logic             st_we;
   logic [SIdxW-1:0] st_wa, st_ra;
   logic [StampBits-1:0] st_wd, st_rd;

   ccl_ram #(.Width(SIdxW+1), .Depth(MaxRomChunks)) u_map (
      .clock, .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(map_ra), .rd_data(map_rd));
   ccl_ram #(.Width(ChunkW+1), .Depth(CacheSlots)) u_slot_chunk (
      .clock, .wr_en(sc_we), .wr_addr(sc_wa), .wr_data(sc_wd),
      .rd_addr(sc_ra), .rd_data(sc_rd));
   ccl_ram #(.Width(StampBits), .Depth(CacheSlots)) u_stamp (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));

   assign chunk     = q_item.offset[31:ChunkSh];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      scan_ff    <= scan_in;
      best_ff    <= best_in;
      best_st_ff <= best_st_in;
      if (rsp_load) rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_pend_ff  <= 1'b0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
         clr_ff   <= clr_in;
         // hold a clear request that arrives while busy; idle takes it directly
         if (clear_req && state_ff != BK_IDLE) clr_pend_ff <= 1'b1;
         else if (state_ff == BK_IDLE) clr_pend_ff <= 1'b0;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_take) rsp_valid_ff <= 1'b0;
      end
   end

   logic [ChunkW-1:0] cur_chunk;
   assign cur_chunk = cur_ff.offset[31:ChunkSh];

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      ctr_in     = ctr_ff;
      cur_in     = cur_ff;
      scan_in    = scan_ff;
      best_in    = best_ff;
      best_st_in = best_st_ff;
      rsp_in     = '0;
      rsp_load   = 1'b0;
      q_pop      = 1'b0;
      map_we = 1'b0; map_wa = '0; map_wd = '0; map_ra = '0;
      sc_we  = 1'b0; sc_wa  = '0; sc_wd  = '0; sc_ra  = '0;
      st_we  = 1'b0; st_wa  = '0; st_wd  = '0; st_ra  = '0;
      case (state_ff)
         BK_CLEAR: begin
            // wipe map, slot table and stamps, one entry per cycle
            map_we = (clr_ff < ClrW'(MaxRomChunks));
            map_wa = MapW'(clr_ff);
            sc_we  = (clr_ff < ClrW'(CacheSlots));
            sc_wa  = SIdxW'(clr_ff);
            st_we  = sc_we;
            st_wa  = SIdxW'(clr_ff);
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ClrW'(ClrN - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            clr_in = '0;
            if (clear_req || clr_pend_ff) begin
               state_in = BK_CLEAR;
            end else if (q_valid && (!rsp_valid_ff || rsp_take)) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               if (!q_item.in_range) begin
                  rsp_load = 1'b1;
               end else begin
                  map_ra   = MapW'(chunk);
                  state_in = BK_MAP_RD;
               end
            end
         end
         BK_MAP_RD: begin
            if (map_rd[SIdxW]) begin
               // hit: restamp and answer
               st_we  = 1'b1;
               st_wa  = map_rd[SIdxW-1:0];
               st_wd  = ctr_ff + 1'b1;
               ctr_in = ctr_ff + 1'b1;
               rsp_in.in_range    = 1'b1;
               rsp_in.slot        = SlotW'(map_rd[SIdxW-1:0]);
               rsp_in.chunk_start = {cur_chunk, ChunkSh'(0)};
               rsp_load = 1'b1;
               state_in = BK_IDLE;
            end else begin
               st_ra      = '0;
               scan_in    = '0;
               best_in    = '0;
               best_st_in = '1;
               state_in   = BK_SCAN;
            end
         end
         BK_SCAN: begin
            // read stamp scan_ff+1 while stamp scan_ff arrives
            st_ra   = SIdxW'(scan_ff + 1'b1);
            scan_in = scan_ff + 1'b1;
            if (scan_ff == '0 || st_rd < best_st_ff) begin
               best_in    = SIdxW'(scan_ff);
               best_st_in = st_rd;
            end
            if (scan_ff == (SIdxW+1)'(CacheSlots - 1)) begin
               state_in = BK_SLOT_RD;
            end
         end
         BK_SLOT_RD: begin
            sc_ra    = best_ff;
            state_in = BK_FIX;
         end
         BK_FIX: begin
            // evict old owner, install new chunk
            if (sc_rd[ChunkW] && sc_rd[ChunkW-1:0] < ChunkW'(MaxRomChunks)) begin
               map_we = 1'b1;
               map_wa = MapW'(sc_rd[ChunkW-1:0]);
               map_wd = '0;
            end
            sc_we  = 1'b1;
            sc_wa  = best_ff;
            sc_wd  = {1'b1, cur_chunk};
            st_we  = 1'b1;
            st_wa  = best_ff;
            st_wd  = ctr_ff + 2'd2;
            ctr_in = ctr_ff + 2'd2;
            rsp_in.in_range      = 1'b1;
            rsp_in.slot          = SlotW'(best_ff);
            rsp_in.chunk_start   = {cur_chunk, ChunkSh'(0)};
            rsp_in.load_needed   = 1'b1;
            rsp_in.evicted_valid = sc_rd[ChunkW];
            rsp_in.evicted_chunk = sc_rd[ChunkW] ? EvChunkW'(sc_rd[ChunkW-1:0]) : '0;
            rsp_load = 1'b1;
            state_in = BK_DONE;
         end
         BK_DONE: begin
            // install map entry on its own port cycle
            map_we   = 1'b1;
            map_wa   = MapW'(cur_chunk);
            map_wd   = {1'b1, best_ff};
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   `CCL_ASSERT_IMP(a_pop_idle, clock, reset, q_pop, state_ff == BK_IDLE)
   `CCL_ASSERT_IMP(a_load_free, clock, reset, rsp_load, !rsp_valid_ff || rsp_take)
   `CCL_ASSERT_NEXT(a_fix_done, clock, reset, state_ff == BK_FIX, state_ff == BK_DONE)
endmodule
`default_nettype wire
